// ----- rtl/abepc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio band envelope and phase clock: shared package
// Types, constants and small tables used by the controller and the datapath.
// ----------------------------------------------------------------------------
package abepc_pkg;

   localparam int unsigned NUM_SLICES = 5;
   localparam int unsigned SLICE_W    = 3;
   localparam int unsigned BIN_W      = 4;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned DT_W       = 6;
   localparam int unsigned KICK_W     = 10;
   localparam int unsigned PHASE_W    = 16;
   localparam int unsigned MULA_W     = 10;
   localparam int unsigned MULB_W     = 6;
   localparam int unsigned PROD_W     = 16;
   localparam int unsigned MAG_W      = 17;
   localparam int unsigned SH_W       = 5;
   localparam int unsigned WIDE_W     = PROD_W + MAG_W;
   localparam int unsigned CSR_IDX_W  = 2;

   localparam logic [SLICE_W-1:0] LAST_SLICE  = SLICE_W'(NUM_SLICES - 1);
   localparam logic [SLICE_W-1:0] TOP_SLICE_A = SLICE_W'(NUM_SLICES - 2);
   localparam logic [SLICE_W-1:0] TOP_SLICE_B = SLICE_W'(NUM_SLICES - 1);

   localparam logic [BYTE_W-1:0]  DT_MAX      = 8'd60;
   localparam logic [KICK_W:0]    KICK_CAP    = 11'd620;
   localparam logic [PHASE_W-1:0] GIVE_PHASE  = 16'd30;
   localparam int unsigned        PHASE_STEP  = 9000;
   localparam logic [MULA_W-1:0]  SPEED_BIAS  = 10'd2;
   localparam logic [BYTE_W-1:0]  SPEED_RESET = 8'd90;

   localparam logic [CSR_IDX_W-1:0] REG_SPEED       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BEAT_ENABLE = 2'd1;

   // Exact division of a 16-bit value by a constant: q = (x * M) >> S with
   // S = 16 + ceil(log2(D)) and M = ceil(2^S / D).
   localparam int unsigned DIV_ATTACK    = 160;
   localparam int unsigned DIV_REL_LEVEL = 380;
   localparam int unsigned DIV_REL_LOUD  = 600;
   localparam int unsigned DIV_SHARP     = 250;
   localparam int unsigned DIV_GIVE      = 70;
   localparam int unsigned DIV_THIRD     = 3;
   localparam int unsigned DIV_RATE      = 23;
   localparam int unsigned DIV_FIFTH     = 5;
   localparam int unsigned DIV_DRIFT     = 120;

   localparam int unsigned SH_ATTACK    = 16 + $clog2(DIV_ATTACK);
   localparam int unsigned SH_REL_LEVEL = 16 + $clog2(DIV_REL_LEVEL);
   localparam int unsigned SH_REL_LOUD  = 16 + $clog2(DIV_REL_LOUD);
   localparam int unsigned SH_SHARP     = 16 + $clog2(DIV_SHARP);
   localparam int unsigned SH_GIVE      = 16 + $clog2(DIV_GIVE);
   localparam int unsigned SH_THIRD     = 16 + $clog2(DIV_THIRD);
   localparam int unsigned SH_RATE      = 16 + $clog2(DIV_RATE);
   localparam int unsigned SH_FIFTH     = 16 + $clog2(DIV_FIFTH);
   localparam int unsigned SH_DRIFT     = 16 + $clog2(DIV_DRIFT);

   localparam logic [MAG_W-1:0] M_ATTACK =
      MAG_W'(((64'd1 << SH_ATTACK) + DIV_ATTACK - 1) / DIV_ATTACK);
   localparam logic [MAG_W-1:0] M_REL_LEVEL =
      MAG_W'(((64'd1 << SH_REL_LEVEL) + DIV_REL_LEVEL - 1) / DIV_REL_LEVEL);
   localparam logic [MAG_W-1:0] M_REL_LOUD =
      MAG_W'(((64'd1 << SH_REL_LOUD) + DIV_REL_LOUD - 1) / DIV_REL_LOUD);
   localparam logic [MAG_W-1:0] M_SHARP =
      MAG_W'(((64'd1 << SH_SHARP) + DIV_SHARP - 1) / DIV_SHARP);
   localparam logic [MAG_W-1:0] M_GIVE =
      MAG_W'(((64'd1 << SH_GIVE) + DIV_GIVE - 1) / DIV_GIVE);
   localparam logic [MAG_W-1:0] M_THIRD =
      MAG_W'(((64'd1 << SH_THIRD) + DIV_THIRD - 1) / DIV_THIRD);
   localparam logic [MAG_W-1:0] M_RATE =
      MAG_W'(((64'd1 << SH_RATE) + DIV_RATE - 1) / DIV_RATE);
   localparam logic [MAG_W-1:0] M_FIFTH =
      MAG_W'(((64'd1 << SH_FIFTH) + DIV_FIFTH - 1) / DIV_FIFTH);
   localparam logic [MAG_W-1:0] M_DRIFT =
      MAG_W'(((64'd1 << SH_DRIFT) + DIV_DRIFT - 1) / DIV_DRIFT);

   typedef enum logic [2:0] {
      OP_LEVEL  = 3'd0,
      OP_LOUD   = 3'd1,
      OP_SHARP  = 3'd2,
      OP_GIVE   = 3'd3,
      OP_SPEED3 = 3'd4,
      OP_RATE   = 3'd5,
      OP_PHASE  = 3'd6,
      OP_DRIFT  = 3'd7
   } op_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_DIV  = 6'b000100,
      ST_WB   = 6'b001000,
      ST_LOAD = 6'b010000,
      ST_SEND = 6'b100000
   } state_type;

   typedef struct packed {
      logic               accept;
      logic               capture;
      logic               stage1;
      logic               stage2;
      logic               wb;
      op_type             op;
      logic [SLICE_W-1:0] slice;
      logic               load_out;
      logic               clear_peaks;
   } dp_cmd_type;

   function automatic logic [SLICE_W-1:0] bin_slice(input logic [BIN_W-1:0] idx);
      logic [SLICE_W-1:0] s;
      unique case (idx)
         4'd0, 4'd1:                s = 3'd0;
         4'd2, 4'd3, 4'd4:          s = 3'd1;
         4'd5, 4'd6, 4'd7:          s = 3'd2;
         4'd8, 4'd9, 4'd10, 4'd11:  s = 3'd3;
         default:                   s = 3'd4;
      endcase
      return s;
   endfunction

   function automatic logic [MULB_W-1:0] clock_rate(input logic [SLICE_W-1:0] slice);
      logic [MULB_W-1:0] r;
      unique case (slice)
         3'd0:    r = 6'd5;
         3'd1:    r = 6'd8;
         3'd2:    r = 6'd12;
         3'd3:    r = 6'd17;
         default: r = 6'd23;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/abepc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio band envelope and phase clock: controller
// Sequences the frame update through the shared multiply unit and then hands
// out the five slice results.
// ----------------------------------------------------------------------------
module abepc_ctrl
   import abepc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_frame_last,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [SLICE_W-1:0] slice_ff, slice_in;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      slice_in = slice_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_frame_last) begin
               state_in = ST_MUL;
               op_in    = OP_LEVEL;
               slice_in = '0;
            end
         end
         ST_MUL: state_in = ST_DIV;
         ST_DIV: state_in = ST_WB;
         ST_WB: begin
            state_in = ST_MUL;
            unique case (op_ff)
               OP_LEVEL: begin
                  if (slice_ff == LAST_SLICE) begin
                     op_in    = OP_LOUD;
                     slice_in = '0;
                  end else begin
                     slice_in = slice_ff + SLICE_W'(1);
                  end
               end
               OP_LOUD:   op_in = OP_SHARP;
               OP_SHARP:  op_in = OP_GIVE;
               OP_GIVE:   op_in = OP_SPEED3;
               OP_SPEED3: op_in = OP_RATE;
               OP_RATE: begin
                  op_in    = OP_PHASE;
                  slice_in = '0;
               end
               OP_PHASE: begin
                  if (slice_ff == LAST_SLICE) begin
                     op_in    = OP_DRIFT;
                     slice_in = '0;
                  end else begin
                     slice_in = slice_ff + SLICE_W'(1);
                  end
               end
               default: begin
                  state_in = ST_LOAD;
                  slice_in = '0;
               end
            endcase
         end
         ST_LOAD: state_in = ST_SEND;
         ST_SEND: begin
            if (rsp_ready) begin
               if (slice_ff == LAST_SLICE) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_LOAD;
                  slice_in = slice_ff + SLICE_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_LEVEL;
         slice_ff <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         slice_ff <= slice_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_SEND);

   always_comb begin
      cmd.accept      = req_ready && req_valid;
      cmd.capture     = req_ready && req_valid && req_frame_last;
      cmd.stage1      = (state_ff == ST_MUL);
      cmd.stage2      = (state_ff == ST_DIV);
      cmd.wb          = (state_ff == ST_WB);
      cmd.op          = op_ff;
      cmd.slice       = slice_ff;
      cmd.load_out    = (state_ff == ST_LOAD);
      cmd.clear_peaks = (state_ff == ST_WB) && (op_ff == OP_DRIFT);
   end

endmodule

// ----- rtl/abepc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio band envelope and phase clock: datapath
// Slice peaks and envelopes, loudness, sharpness, kick, phase clocks and
// palette drift, with one two-stage multiply and reciprocal-divide unit.
// ----------------------------------------------------------------------------
module abepc_dp
   import abepc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   input  logic [BIN_W-1:0]     req_bin_index,
   input  logic [BYTE_W-1:0]    req_bin_value,
   input  logic [BYTE_W-1:0]    req_frame_time,
   input  logic [BYTE_W-1:0]    req_loud_target,
   input  logic [BYTE_W-1:0]    req_beat_strength,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data,
   output logic [SLICE_W-1:0]   rsp_slice_index,
   output logic [BYTE_W-1:0]    rsp_slice_level,
   output logic [PHASE_W-1:0]   rsp_slice_phase,
   output logic [BYTE_W-1:0]    rsp_loudness,
   output logic [BYTE_W-1:0]    rsp_sharpness,
   output logic [KICK_W-1:0]    rsp_kick_owed,
   output logic [PHASE_W-1:0]   rsp_palette_drift,
   output logic                 rsp_last_of_frame
);

   logic [BYTE_W-1:0]  speed_ff, speed_in;
   logic               beat_en_ff, beat_en_in;
   logic [BYTE_W-1:0]  peak_ff [NUM_SLICES];
   logic [BYTE_W-1:0]  peak_in [NUM_SLICES];
   logic [BYTE_W-1:0]  level_ff [NUM_SLICES];
   logic [BYTE_W-1:0]  level_in [NUM_SLICES];
   logic [PHASE_W-1:0] phase_ff [NUM_SLICES];
   logic [PHASE_W-1:0] phase_in [NUM_SLICES];
   logic [BYTE_W-1:0]  loud_ff, loud_in;
   logic [BYTE_W-1:0]  sharp_ff, sharp_in;
   logic [KICK_W-1:0]  kick_ff, kick_in;
   logic [PHASE_W-1:0] drift_ff, drift_in;

   logic [DT_W-1:0]    dt_ff, dt_in;
   logic [BYTE_W-1:0]  tgt_ff, tgt_in;
   logic [6:0]         s3_ff, s3_in;
   logic [BYTE_W-1:0]  r_ff, r_in;
   logic [PROD_W-1:0]  p_ff, p_in;
   logic [MAG_W-1:0]   m_ff, m_in;
   logic [SH_W-1:0]    s_ff, s_in;
   logic [WIDE_W-1:0]  wide_ff, wide_in;
   logic [SH_W-1:0]    sh_ff, sh_in;

   logic [SLICE_W-1:0] sl_out_ff, sl_out_in;
   logic [BYTE_W-1:0]  lvl_out_ff, lvl_out_in;
   logic [PHASE_W-1:0] ph_out_ff, ph_out_in;
   logic [BYTE_W-1:0]  loud_out_ff, loud_out_in;
   logic [BYTE_W-1:0]  sharp_out_ff, sharp_out_in;
   logic [KICK_W-1:0]  kick_out_ff, kick_out_in;
   logic [PHASE_W-1:0] drift_out_ff, drift_out_in;
   logic               last_out_ff, last_out_in;

   logic [BYTE_W:0]    top_sum;
   logic [BYTE_W-1:0]  cur, aim, diff;
   logic               up;
   logic [MULA_W-1:0]  mul_a;
   logic [MULB_W-1:0]  mul_b;
   logic [MAG_W-1:0]   mag;
   logic [SH_W-1:0]    shf;
   logic [WIDE_W-1:0]  q_wide;
   logic [PHASE_W-1:0] q;
   logic [PHASE_W:0]   env_sum;
   logic [BYTE_W-1:0]  env_nv;
   logic [PHASE_W-1:0] q_nz;
   logic [KICK_W-1:0]  give;
   logic [KICK_W:0]    kick_sum;
   logic [SLICE_W-1:0] bs;

   // Operand selection for the shared unit.
   always_comb begin
      top_sum = {1'b0, level_ff[TOP_SLICE_A]} + {1'b0, level_ff[TOP_SLICE_B]};
      unique case (cmd.op)
         OP_LEVEL: begin
            cur = level_ff[cmd.slice];
            aim = peak_ff[cmd.slice];
         end
         OP_LOUD: begin
            cur = loud_ff;
            aim = tgt_ff;
         end
         default: begin
            cur = sharp_ff;
            aim = top_sum[BYTE_W:1];
         end
      endcase
      up   = (aim > cur);
      diff = up ? (aim - cur) : (cur - aim);

      unique case (cmd.op)
         OP_LEVEL: begin
            mul_a = {2'b0, diff};
            mul_b = dt_ff;
            mag   = up ? M_ATTACK : M_REL_LEVEL;
            shf   = up ? SH_W'(SH_ATTACK) : SH_W'(SH_REL_LEVEL);
         end
         OP_LOUD: begin
            mul_a = {2'b0, diff};
            mul_b = dt_ff;
            mag   = up ? M_ATTACK : M_REL_LOUD;
            shf   = up ? SH_W'(SH_ATTACK) : SH_W'(SH_REL_LOUD);
         end
         OP_SHARP: begin
            mul_a = {2'b0, diff};
            mul_b = dt_ff;
            mag   = M_SHARP;
            shf   = SH_W'(SH_SHARP);
         end
         OP_GIVE: begin
            mul_a = kick_ff;
            mul_b = dt_ff;
            mag   = M_GIVE;
            shf   = SH_W'(SH_GIVE);
         end
         OP_SPEED3: begin
            mul_a = {2'b0, speed_ff};
            mul_b = MULB_W'(1);
            mag   = M_THIRD;
            shf   = SH_W'(SH_THIRD);
         end
         OP_RATE: begin
            mul_a = SPEED_BIAS + {3'b0, s3_ff};
            mul_b = dt_ff;
            mag   = M_RATE;
            shf   = SH_W'(SH_RATE);
         end
         OP_PHASE: begin
            mul_a = {2'b0, r_ff};
            mul_b = clock_rate(cmd.slice);
            mag   = M_FIFTH;
            shf   = SH_W'(SH_FIFTH);
         end
         default: begin
            mul_a = {2'b0, speed_ff};
            mul_b = dt_ff;
            mag   = M_DRIFT;
            shf   = SH_W'(SH_DRIFT);
         end
      endcase
   end

   // Write-back values.
   always_comb begin
      q_wide   = wide_ff >> sh_ff;
      q        = q_wide[PHASE_W-1:0];
      env_sum  = {9'b0, cur} + {1'b0, q};
      env_nv   = up ? ((env_sum > 17'd255) ? 8'hFF : env_sum[BYTE_W-1:0])
                    : (cur - q[BYTE_W-1:0]);
      q_nz     = (q == '0) ? 16'd1 : q;
      give     = (q_nz > {6'b0, kick_ff}) ? kick_ff : q_nz[KICK_W-1:0];
      kick_sum = {1'b0, kick_ff} + {3'b0, req_beat_strength};
      bs       = bin_slice(req_bin_index);
   end

   always_comb begin
      speed_in   = speed_ff;
      beat_en_in = beat_en_ff;
      peak_in    = peak_ff;
      level_in   = level_ff;
      phase_in   = phase_ff;
      loud_in    = loud_ff;
      sharp_in   = sharp_ff;
      kick_in    = kick_ff;
      drift_in   = drift_ff;

      if (csr_valid) begin
         if (csr_index == REG_SPEED) begin
            speed_in = csr_data;
         end else if (csr_index == REG_BEAT_ENABLE) begin
            beat_en_in = csr_data[0];
         end
      end

      if (cmd.accept && (req_bin_value > peak_ff[bs])) begin
         peak_in[bs] = req_bin_value;
      end
      if (cmd.clear_peaks) begin
         for (int i = 0; i < NUM_SLICES; i++) begin
            peak_in[i] = '0;
         end
      end

      if (cmd.capture && beat_en_ff && (req_beat_strength != '0)) begin
         kick_in = (kick_sum > KICK_CAP) ? KICK_CAP[KICK_W-1:0] : kick_sum[KICK_W-1:0];
      end

      if (cmd.wb) begin
         unique case (cmd.op)
            OP_LEVEL: level_in[cmd.slice] = env_nv;
            OP_LOUD:  loud_in = env_nv;
            OP_SHARP: sharp_in = env_nv;
            OP_GIVE: begin
               if (kick_ff != '0) begin
                  phase_in[0] = phase_ff[0] + PHASE_W'({6'b0, give} * GIVE_PHASE);
                  kick_in     = kick_ff - give;
               end
            end
            OP_PHASE: phase_in[cmd.slice] = phase_ff[cmd.slice] + q;
            OP_DRIFT: drift_in = drift_ff + q;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      dt_in   = dt_ff;
      tgt_in  = tgt_ff;
      s3_in   = s3_ff;
      r_in    = r_ff;
      p_in    = p_ff;
      m_in    = m_ff;
      s_in    = s_ff;
      wide_in = wide_ff;
      sh_in   = sh_ff;
      if (cmd.capture) begin
         dt_in  = (req_frame_time > DT_MAX) ? DT_MAX[DT_W-1:0] : req_frame_time[DT_W-1:0];
         tgt_in = req_loud_target;
      end
      if (cmd.stage1) begin
         p_in = {6'b0, mul_a} * {10'b0, mul_b};
         m_in = mag;
         s_in = shf;
      end
      if (cmd.stage2) begin
         wide_in = {{MAG_W{1'b0}}, p_ff} * {{PROD_W{1'b0}}, m_ff};
         sh_in   = s_ff;
      end
      if (cmd.wb && (cmd.op == OP_SPEED3)) begin
         s3_in = q[6:0];
      end
      if (cmd.wb && (cmd.op == OP_RATE)) begin
         r_in = q[BYTE_W-1:0];
      end
   end

   always_comb begin
      sl_out_in    = sl_out_ff;
      lvl_out_in   = lvl_out_ff;
      ph_out_in    = ph_out_ff;
      loud_out_in  = loud_out_ff;
      sharp_out_in = sharp_out_ff;
      kick_out_in  = kick_out_ff;
      drift_out_in = drift_out_ff;
      last_out_in  = last_out_ff;
      if (cmd.load_out) begin
         sl_out_in    = cmd.slice;
         lvl_out_in   = level_ff[cmd.slice];
         ph_out_in    = phase_ff[cmd.slice];
         loud_out_in  = loud_ff;
         sharp_out_in = sharp_ff;
         kick_out_in  = kick_ff;
         drift_out_in = drift_ff;
         last_out_in  = (cmd.slice == LAST_SLICE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff   <= SPEED_RESET;
         beat_en_ff <= 1'b1;
         for (int i = 0; i < NUM_SLICES; i++) begin
            peak_ff[i]  <= '0;
            level_ff[i] <= '0;
            phase_ff[i] <= PHASE_W'(i * PHASE_STEP);
         end
         loud_ff  <= '0;
         sharp_ff <= '0;
         kick_ff  <= '0;
         drift_ff <= '0;
      end else begin
         speed_ff   <= speed_in;
         beat_en_ff <= beat_en_in;
         peak_ff    <= peak_in;
         level_ff   <= level_in;
         phase_ff   <= phase_in;
         loud_ff    <= loud_in;
         sharp_ff   <= sharp_in;
         kick_ff    <= kick_in;
         drift_ff   <= drift_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff        <= dt_in;
      tgt_ff       <= tgt_in;
      s3_ff        <= s3_in;
      r_ff         <= r_in;
      p_ff         <= p_in;
      m_ff         <= m_in;
      s_ff         <= s_in;
      wide_ff      <= wide_in;
      sh_ff        <= sh_in;
      sl_out_ff    <= sl_out_in;
      lvl_out_ff   <= lvl_out_in;
      ph_out_ff    <= ph_out_in;
      loud_out_ff  <= loud_out_in;
      sharp_out_ff <= sharp_out_in;
      kick_out_ff  <= kick_out_in;
      drift_out_ff <= drift_out_in;
      last_out_ff  <= last_out_in;
   end

   assign rsp_slice_index   = sl_out_ff;
   assign rsp_slice_level   = lvl_out_ff;
   assign rsp_slice_phase   = ph_out_ff;
   assign rsp_loudness      = loud_out_ff;
   assign rsp_sharpness     = sharp_out_ff;
   assign rsp_kick_owed     = kick_out_ff;
   assign rsp_palette_drift = drift_out_ff;
   assign rsp_last_of_frame = last_out_ff;

endmodule

// ----- rtl/audio_band_envelope_and_phase_clock_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio band envelope and phase clock: top level
// Collects FFT bins into five slice peaks and, on the closing bin of each
// frame, updates envelopes, loudness, sharpness, kick, phase clocks and drift.
// ----------------------------------------------------------------------------
// A bin request that does not close its frame is taken while idle; the
// closing one starts a frame update of sixteen steps (five slice envelopes,
// loudness, sharpness, kick payment, two speed terms, five phase clocks and
// the drift), each through the single multiply and reciprocal-divide unit
// in states MUL, DIV and WB. The five results follow, each via LOAD and SEND
// plus any wait on rsp_ready, and the next request is taken once the fifth
// result has gone out. Configuration writes are taken in any cycle.
module audio_band_envelope_and_phase_clock_core
   import abepc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [BIN_W-1:0]     req_bin_index,
   input  logic [BYTE_W-1:0]    req_bin_value,
   input  logic                 req_frame_last,
   input  logic [BYTE_W-1:0]    req_frame_time,
   input  logic [BYTE_W-1:0]    req_loud_target,
   input  logic [BYTE_W-1:0]    req_beat_strength,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [SLICE_W-1:0]   rsp_slice_index,
   output logic [BYTE_W-1:0]    rsp_slice_level,
   output logic [PHASE_W-1:0]   rsp_slice_phase,
   output logic [BYTE_W-1:0]    rsp_loudness,
   output logic [BYTE_W-1:0]    rsp_sharpness,
   output logic [KICK_W-1:0]    rsp_kick_owed,
   output logic [PHASE_W-1:0]   rsp_palette_drift,
   output logic                 rsp_last_of_frame,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data
);

   dp_cmd_type cmd;

   assign csr_ready = 1'b1;

   abepc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_frame_last (req_frame_last),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .cmd            (cmd)
   );

   abepc_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_bin_index     (req_bin_index),
      .req_bin_value     (req_bin_value),
      .req_frame_time    (req_frame_time),
      .req_loud_target   (req_loud_target),
      .req_beat_strength (req_beat_strength),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_slice_index   (rsp_slice_index),
      .rsp_slice_level   (rsp_slice_level),
      .rsp_slice_phase   (rsp_slice_phase),
      .rsp_loudness      (rsp_loudness),
      .rsp_sharpness     (rsp_sharpness),
      .rsp_kick_owed     (rsp_kick_owed),
      .rsp_palette_drift (rsp_palette_drift),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

// ----- rtl/abepc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio band envelope and phase clock: port checker
// Checks result ordering and handshake behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module abepc_checker
   import abepc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [SLICE_W-1:0] rsp_slice_index,
   input logic [BYTE_W-1:0]  rsp_slice_level,
   input logic [PHASE_W-1:0] rsp_slice_phase,
   input logic [BYTE_W-1:0]  rsp_loudness,
   input logic [BYTE_W-1:0]  rsp_sharpness,
   input logic [KICK_W-1:0]  rsp_kick_owed,
   input logic [PHASE_W-1:0] rsp_palette_drift,
   input logic               rsp_last_of_frame
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_slice_index,
         rsp_slice_level, rsp_slice_phase, rsp_loudness, rsp_sharpness,
         rsp_kick_owed, rsp_palette_drift, rsp_last_of_frame}))
      else $error("Result changed while stalled.");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("Request taken while a result is pending.");

   a_frame_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_frame |=> !req_ready)
      else $error("Request taken before the frame's last result.");

   a_last_slice: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_of_frame == (rsp_slice_index == LAST_SLICE)))
      else $error("Last-of-frame flag does not match the final slice.");

   a_kick_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_kick_owed} <= KICK_CAP))
      else $error("Kick owed above its cap.");

endmodule

bind audio_band_envelope_and_phase_clock_core abepc_checker u_abepc_checker (.*);

// ----- sim/tb_audio_band_envelope_and_phase_clock_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the audio band envelope and phase clock core
// Feeds FFT bin requests in frames under changing speed and beat settings,
// predicts the five slice reports that close each frame, and compares every
// report field by field while both handshakes stall at random.
// ----------------------------------------------------------------------------
import abepc_pkg::*;

typedef struct packed {
   logic [BIN_W-1:0]  bin_index;
   logic [BYTE_W-1:0] bin_value;
   logic              frame_last;
   logic [BYTE_W-1:0] frame_time;
   logic [BYTE_W-1:0] loud_target;
   logic [BYTE_W-1:0] beat_strength;
} bin_request_type;

typedef struct packed {
   logic [SLICE_W-1:0] slice_index;
   logic [BYTE_W-1:0]  slice_level;
   logic [PHASE_W-1:0] slice_phase;
   logic [BYTE_W-1:0]  loudness;
   logic [BYTE_W-1:0]  sharpness;
   logic [KICK_W-1:0]  kick_owed;
   logic [PHASE_W-1:0] palette_drift;
   logic               last_of_frame;
} slice_report_type;

class envelope_scoreboard;
   logic [BYTE_W-1:0]  speed;
   logic               beat_on;
   logic [BYTE_W-1:0]  peak [NUM_SLICES];
   logic [BYTE_W-1:0]  level [NUM_SLICES];
   logic [PHASE_W-1:0] phase [NUM_SLICES];
   logic [BYTE_W-1:0]  loud;
   logic [BYTE_W-1:0]  sharp;
   logic [KICK_W-1:0]  kick;
   logic [PHASE_W-1:0] drift;
   slice_report_type   expected_reports [$];
   int unsigned        failures;

   function new();
      speed = SPEED_RESET;
      beat_on = 1'b1;
      for (int b = 0; b < NUM_SLICES; b++) begin
         peak[b] = '0;
         level[b] = '0;
         phase[b] = PHASE_W'(b * 9000);
      end
      loud = '0;
      sharp = '0;
      kick = '0;
      drift = '0;
      failures = 0;
   endfunction

   function void write_register(logic [CSR_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
      if (idx == REG_SPEED) begin
         speed = data;
      end else if (idx == REG_BEAT_ENABLE) begin
         beat_on = data[0];
      end
   endfunction

   function int unsigned slice_of(logic [BIN_W-1:0] idx);
      if (idx < 2) return 0;
      if (idx < 5) return 1;
      if (idx < 8) return 2;
      if (idx < 12) return 3;
      return 4;
   endfunction

   function int unsigned phase_step(int unsigned b);
      case (b)
         0: return 5;
         1: return 8;
         2: return 12;
         3: return 17;
         default: return 23;
      endcase
   endfunction

   function logic [BYTE_W-1:0] approach(int unsigned cur, int unsigned aim, int unsigned dt,
                                        int unsigned rel);
      int unsigned nv;
      if (aim > cur) begin
         nv = cur + ((aim - cur) * dt) / 160;
         if (nv > 255) nv = 255;
      end else begin
         nv = cur - ((cur - aim) * dt) / rel;
      end
      return BYTE_W'(nv);
   endfunction

   function void close_frame(bin_request_type r);
      int unsigned dt;
      int unsigned k;
      int unsigned give;
      int unsigned rate;
      int aim;
      int cur;
      int nv;
      slice_report_type rep;
      dt = (r.frame_time > 60) ? 60 : r.frame_time;
      for (int b = 0; b < NUM_SLICES; b++) level[b] = approach(level[b], peak[b], dt, 380);
      loud = approach(loud, r.loud_target, dt, 600);
      aim = (int'(level[3]) + int'(level[4])) / 2;
      cur = int'(sharp);
      nv = cur + ((aim - cur) * int'(dt)) / 250;
      if (nv < 0) nv = 0;
      if (nv > 255) nv = 255;
      sharp = BYTE_W'(nv);
      if (beat_on && r.beat_strength != 0) begin
         k = int'(kick) + r.beat_strength;
         if (k > 620) k = 620;
         kick = KICK_W'(k);
      end
      if (kick != 0) begin
         give = (int'(kick) * dt) / 70;
         if (give == 0) give = 1;
         if (give > kick) give = kick;
         phase[0] = PHASE_W'(int'(phase[0]) + give * 30);
         kick = KICK_W'(int'(kick) - give);
      end
      rate = ((2 + int'(speed) / 3) * dt) / 23;
      for (int b = 0; b < NUM_SLICES; b++)
         phase[b] = PHASE_W'(int'(phase[b]) + (rate * phase_step(b)) / 5);
      drift = PHASE_W'(int'(drift) + (dt * speed) / 120);
      for (int b = 0; b < NUM_SLICES; b++) begin
         rep.slice_index = SLICE_W'(b);
         rep.slice_level = level[b];
         rep.slice_phase = phase[b];
         rep.loudness = loud;
         rep.sharpness = sharp;
         rep.kick_owed = kick;
         rep.palette_drift = drift;
         rep.last_of_frame = (b == NUM_SLICES - 1);
         expected_reports.push_back(rep);
         peak[b] = '0;
      end
   endfunction

   function void note_request(bin_request_type r);
      int unsigned s;
      s = slice_of(r.bin_index);
      if (r.bin_value > peak[s]) peak[s] = r.bin_value;
      if (r.frame_last) close_frame(r);
   endfunction

   function void compare_field(string name, int unsigned slice, int unsigned exp_v,
                               int unsigned act_v);
      if (exp_v != act_v) begin
         failures++;
         $display("%0t: slice %0d %s mismatch: expected %0d, actual %0d",
                  $time, slice, name, exp_v, act_v);
      end
   endfunction

   function void check_report(slice_report_type act);
      slice_report_type exp_r;
      if (expected_reports.size() == 0) begin
         failures++;
         $display("%0t: unexpected report: expected none, actual slice %0d level %0d",
                  $time, act.slice_index, act.slice_level);
         return;
      end
      exp_r = expected_reports.pop_front();
      compare_field("slice_index", exp_r.slice_index, exp_r.slice_index, act.slice_index);
      compare_field("slice_level", exp_r.slice_index, exp_r.slice_level, act.slice_level);
      compare_field("slice_phase", exp_r.slice_index, exp_r.slice_phase, act.slice_phase);
      compare_field("loudness", exp_r.slice_index, exp_r.loudness, act.loudness);
      compare_field("sharpness", exp_r.slice_index, exp_r.sharpness, act.sharpness);
      compare_field("kick_owed", exp_r.slice_index, exp_r.kick_owed, act.kick_owed);
      compare_field("palette_drift", exp_r.slice_index, exp_r.palette_drift,
                    act.palette_drift);
      compare_field("last_of_frame", exp_r.slice_index, exp_r.last_of_frame,
                    act.last_of_frame);
   endfunction

   function int unsigned pending();
      return expected_reports.size();
   endfunction
endclass

module tb_audio_band_envelope_and_phase_clock_core;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYCLES = 12;
   localparam int unsigned PHASE_ITEMS   = 20;
   localparam int unsigned NUM_PHASES    = 6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [BIN_W-1:0]     req_bin_index;
   logic [BYTE_W-1:0]    req_bin_value;
   logic                 req_frame_last;
   logic [BYTE_W-1:0]    req_frame_time;
   logic [BYTE_W-1:0]    req_loud_target;
   logic [BYTE_W-1:0]    req_beat_strength;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [SLICE_W-1:0]   rsp_slice_index;
   logic [BYTE_W-1:0]    rsp_slice_level;
   logic [PHASE_W-1:0]   rsp_slice_phase;
   logic [BYTE_W-1:0]    rsp_loudness;
   logic [BYTE_W-1:0]    rsp_sharpness;
   logic [KICK_W-1:0]    rsp_kick_owed;
   logic [PHASE_W-1:0]   rsp_palette_drift;
   logic                 rsp_last_of_frame;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_data;

   envelope_scoreboard sb;
   int unsigned        cycles;
   int unsigned        phase_items;

   audio_band_envelope_and_phase_clock_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_bin_index     (req_bin_index),
      .req_bin_value     (req_bin_value),
      .req_frame_last    (req_frame_last),
      .req_frame_time    (req_frame_time),
      .req_loud_target   (req_loud_target),
      .req_beat_strength (req_beat_strength),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_slice_index   (rsp_slice_index),
      .rsp_slice_level   (rsp_slice_level),
      .rsp_slice_phase   (rsp_slice_phase),
      .rsp_loudness      (rsp_loudness),
      .rsp_sharpness     (rsp_sharpness),
      .rsp_kick_owed     (rsp_kick_owed),
      .rsp_palette_drift (rsp_palette_drift),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int unsigned idle_len();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 50) return 0;
      if (k < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic bin_request_type make_bin(int unsigned idx, int unsigned val, bit last,
                                                int unsigned dt, int unsigned loud,
                                                int unsigned beat);
      bin_request_type r;
      r.bin_index = BIN_W'(idx);
      r.bin_value = BYTE_W'(val);
      r.frame_last = last;
      r.frame_time = BYTE_W'(dt);
      r.loud_target = BYTE_W'(loud);
      r.beat_strength = BYTE_W'(beat);
      return r;
   endfunction

   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_ready <= 1'b0;
            repeat (idle_len()) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      slice_report_type act;
      if (!reset && rsp_valid && rsp_ready) begin
         act.slice_index = rsp_slice_index;
         act.slice_level = rsp_slice_level;
         act.slice_phase = rsp_slice_phase;
         act.loudness = rsp_loudness;
         act.sharpness = rsp_sharpness;
         act.kick_owed = rsp_kick_owed;
         act.palette_drift = rsp_palette_drift;
         act.last_of_frame = rsp_last_of_frame;
         sb.check_report(act);
      end
   end

   task automatic send_bin(bin_request_type r);
      int unsigned gap;
      gap = idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_bin_index <= r.bin_index;
      req_bin_value <= r.bin_value;
      req_frame_last <= r.frame_last;
      req_frame_time <= r.frame_time;
      req_loud_target <= r.loud_target;
      req_beat_strength <= r.beat_strength;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      phase_items++;
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int unsigned pick_value();
      int unsigned k;
      k = $urandom_range(0, 9);
      if (k == 0) return 0;
      if (k == 1) return 255;
      return $urandom_range(0, 255);
   endfunction

   function automatic int unsigned pick_time();
      int unsigned k;
      k = $urandom_range(0, 9);
      if (k < 6) return $urandom_range(0, 60);
      if (k < 8) return $urandom_range(0, 5);
      return $urandom_range(0, 255);
   endfunction

   task automatic random_frame();
      int unsigned mode;
      int unsigned len;
      int unsigned idx;
      int unsigned beat;
      mode = $urandom_range(0, 9);
      if (mode < 6) len = 16;
      else if (mode < 8) len = $urandom_range(1, 16);
      else len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) begin
         idx = (len == 16) ? i : $urandom_range(0, 15);
         if (i == len - 1) begin
            beat = ($urandom_range(0, 9) < 5) ? 0 : $urandom_range(1, 255);
            send_bin(make_bin(idx, pick_value(), 1'b1, pick_time(),
                              $urandom_range(0, 255), beat));
         end else begin
            send_bin(make_bin(idx, pick_value(), 1'b0, $urandom_range(0, 255),
                              $urandom_range(0, 255), $urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      logic [BYTE_W-1:0] spd;
      logic              beat_en;
      sb = new();
      cycles = 0;
      phase_items = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_bin_index <= '0;
      req_bin_value <= '0;
      req_frame_last <= 1'b0;
      req_frame_time <= '0;
      req_loud_target <= '0;
      req_beat_strength <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_csr(REG_SPEED, 8'd255);
      write_csr(REG_BEAT_ENABLE, 8'hFF);
      write_csr(REG_SPARE_A, BYTE_W'($urandom_range(0, 255)));
      write_csr(REG_SPARE_B, BYTE_W'($urandom_range(0, 255)));

      // Full-scale frame with every bin, an over-range frame time and a full beat.
      for (int i = 0; i < 15; i++) send_bin(make_bin(i, 255, 1'b0, 0, 0, 0));
      send_bin(make_bin(15, 255, 1'b1, 255, 255, 255));
      // Same bin twice, most slices never delivered, zero frame time with kick owed.
      send_bin(make_bin(3, 10, 1'b0, 255, 255, 255));
      send_bin(make_bin(3, 200, 1'b0, 0, 0, 0));
      send_bin(make_bin(0, 0, 1'b1, 0, 0, 255));
      // Frames closed by their only bin; kick driven into its cap.
      send_bin(make_bin(8, 128, 1'b1, 1, 0, 255));
      send_bin(make_bin(12, 0, 1'b1, 61, 0, 255));
      send_bin(make_bin(15, 0, 1'b1, 60, 128, 0));
      wait_idle();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: spd = 8'd0;
            1: spd = 8'd255;
            2: spd = SPEED_RESET;
            default: spd = BYTE_W'($urandom_range(0, 255));
         endcase
         beat_en = (p == 1 || p == 3) ? 1'b0 : ((p == 0) ? 1'b1 : 1'($urandom_range(0, 1)));
         write_csr(REG_SPEED, spd);
         write_csr(REG_BEAT_ENABLE, {7'($urandom_range(0, 127)), beat_en});
         if (p == 2) begin
            write_csr(REG_SPARE_A, BYTE_W'($urandom_range(0, 255)));
            write_csr(REG_SPARE_B, BYTE_W'($urandom_range(0, 255)));
         end
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) random_frame();
         wait_idle();
      end

      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- audio_band_envelope_and_phase_clock_core.f -----
rtl/abepc_pkg.sv
rtl/abepc_ctrl.sv
rtl/abepc_dp.sv
rtl/audio_band_envelope_and_phase_clock_core.sv
rtl/abepc_checker.sv
sim/tb_audio_band_envelope_and_phase_clock_core.sv
